[hdl/dswl_pkg.sv]
// Package for the dual-sensor wipe light controller.
// Mode codes, register indexes, reset values and the shared structs.
// No dependencies.
package dswl_pkg;

	localparam int LEN_W   = 9;
	localparam int PIX_W   = 8;
	localparam int COLOR_W = 8;
	localparam int CNT_W   = 32;
	localparam int IDX_W   = 2;

	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_ASC  = 2'd1;
	localparam logic [1:0] MODE_DESC = 2'd2;
	localparam logic [1:0] MODE_HOLD = 2'd3;

	localparam logic [IDX_W-1:0] REG_STRIP_LENGTH = 2'd0;
	localparam logic [IDX_W-1:0] REG_WIPE_RED     = 2'd1;
	localparam logic [IDX_W-1:0] REG_WIPE_GREEN   = 2'd2;
	localparam logic [IDX_W-1:0] REG_WIPE_BLUE    = 2'd3;

	localparam logic [LEN_W-1:0]   RST_STRIP_LENGTH = 9'd60;
	localparam logic [COLOR_W-1:0] RST_WIPE_RED     = 8'd50;
	localparam logic [COLOR_W-1:0] RST_WIPE_GREEN   = 8'd40;
	localparam logic [COLOR_W-1:0] RST_WIPE_BLUE    = 8'd0;

	typedef struct packed {
		logic [1:0]       mode;
		logic             prev_left;
		logic             prev_right;
		logic [PIX_W-1:0] position;
		logic             started;
		logic [CNT_W-1:0] left_count;
		logic [CNT_W-1:0] right_count;
		logic [CNT_W-1:0] conflict_count;
	} state_t;

	typedef struct packed {
		logic [LEN_W-1:0]   length;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic               pixel_write;
		logic [PIX_W-1:0]   pixel_index;
		logic [COLOR_W-1:0] pixel_red;
		logic [COLOR_W-1:0] pixel_green;
		logic [COLOR_W-1:0] pixel_blue;
		logic               clear_strip;
		logic [CNT_W-1:0]   left_triggers;
		logic [CNT_W-1:0]   right_triggers;
		logic [CNT_W-1:0]   conflicts;
	} result_t;

endpackage

[hdl/dswl_in_if.sv]
// Sensor tick channel: valid/ready plus the two sensor levels.
// No dependencies.
interface dswl_in_if;
	logic valid;
	logic ready;
	logic sensor_left;
	logic sensor_right;

	modport source (output valid, output sensor_left, output sensor_right, input ready);
	modport sink (input valid, input sensor_left, input sensor_right, output ready);
endinterface

[hdl/dswl_out_if.sv]
// Result channel: valid/ready plus the pixel command and counters.
// Depends on dswl_pkg.
interface dswl_out_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    mode;
	logic                          pixel_write;
	logic [dswl_pkg::PIX_W-1:0]    pixel_index;
	logic [dswl_pkg::COLOR_W-1:0]  pixel_red;
	logic [dswl_pkg::COLOR_W-1:0]  pixel_green;
	logic [dswl_pkg::COLOR_W-1:0]  pixel_blue;
	logic                          clear_strip;
	logic [dswl_pkg::CNT_W-1:0]    left_triggers;
	logic [dswl_pkg::CNT_W-1:0]    right_triggers;
	logic [dswl_pkg::CNT_W-1:0]    conflicts;

	modport source (output valid, output mode, output pixel_write, output pixel_index,
		output pixel_red, output pixel_green, output pixel_blue, output clear_strip,
		output left_triggers, output right_triggers, output conflicts, input ready);
	modport sink (input valid, input mode, input pixel_write, input pixel_index,
		input pixel_red, input pixel_green, input pixel_blue, input clear_strip,
		input left_triggers, input right_triggers, input conflicts, output ready);
endinterface

[hdl/dswl_cfg_regs.sv]
// Configuration registers and clamping of the strip length to 1..MAX_PIXELS.
// Depends on dswl_pkg.
module dswl_cfg_regs #(
	parameter int MAX_PIXELS = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [dswl_pkg::IDX_W-1:0]    cfg_index,
	input  logic [dswl_pkg::LEN_W-1:0]    cfg_data,
	output dswl_pkg::cfg_t                cfg
);

	localparam logic [dswl_pkg::LEN_W-1:0] MaxLen = dswl_pkg::LEN_W'(MAX_PIXELS);

	logic [dswl_pkg::LEN_W-1:0]   length_q;
	logic [dswl_pkg::COLOR_W-1:0] red_q;
	logic [dswl_pkg::COLOR_W-1:0] green_q;
	logic [dswl_pkg::COLOR_W-1:0] blue_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= dswl_pkg::RST_STRIP_LENGTH;
			red_q    <= dswl_pkg::RST_WIPE_RED;
			green_q  <= dswl_pkg::RST_WIPE_GREEN;
			blue_q   <= dswl_pkg::RST_WIPE_BLUE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dswl_pkg::REG_STRIP_LENGTH: length_q <= cfg_data;
				dswl_pkg::REG_WIPE_RED:     red_q    <= cfg_data[dswl_pkg::COLOR_W-1:0];
				dswl_pkg::REG_WIPE_GREEN:   green_q  <= cfg_data[dswl_pkg::COLOR_W-1:0];
				dswl_pkg::REG_WIPE_BLUE:    blue_q   <= cfg_data[dswl_pkg::COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		priority if (length_q == '0) begin
			cfg.length = dswl_pkg::LEN_W'(1);
		end else if (length_q > MaxLen) begin
			cfg.length = MaxLen;
		end else begin
			cfg.length = length_q;
		end
		cfg.red   = red_q;
		cfg.green = green_q;
		cfg.blue  = blue_q;
	end

endmodule

[hdl/dswl_step.sv]
// Next-state and result logic for one sensor tick.
// Depends on dswl_pkg.
module dswl_step (
	input  dswl_pkg::state_t  st,
	input  dswl_pkg::cfg_t    cfg,
	input  logic              cl,
	input  logic              cr,
	output dswl_pkg::state_t  nxt,
	output dswl_pkg::result_t res
);

	logic                         edge_l;
	logic                         edge_r;
	logic                         keep_hist;
	logic [dswl_pkg::LEN_W-1:0]   pos_w;
	logic [dswl_pkg::LEN_W-1:0]   pos_inc;
	logic [dswl_pkg::LEN_W-1:0]   desc_idx;

	assign edge_l   = cl && !st.prev_left;
	assign edge_r   = cr && !st.prev_right;
	assign pos_w    = {1'b0, st.position};
	assign pos_inc  = pos_w + dswl_pkg::LEN_W'(1);
	assign desc_idx = cfg.length - pos_inc;

	always_comb begin
		nxt       = st;
		keep_hist = 1'b0;
		res       = '0;
		unique case (st.mode)
			dswl_pkg::MODE_IDLE: begin
				if (edge_l) begin
					nxt.mode       = dswl_pkg::MODE_ASC;
					nxt.left_count = st.left_count + dswl_pkg::CNT_W'(1);
					if (edge_r)
						nxt.conflict_count = st.conflict_count + dswl_pkg::CNT_W'(1);
					nxt.position = '0;
					nxt.started  = 1'b0;
				end else if (edge_r) begin
					nxt.mode        = dswl_pkg::MODE_DESC;
					nxt.right_count = st.right_count + dswl_pkg::CNT_W'(1);
					nxt.position    = '0;
					nxt.started     = 1'b0;
				end
			end
			dswl_pkg::MODE_ASC, dswl_pkg::MODE_DESC: begin
				keep_hist   = st.started;
				nxt.started = 1'b1;
				if (pos_w >= cfg.length) begin
					nxt.mode     = dswl_pkg::MODE_HOLD;
					nxt.position = '0;
					nxt.started  = 1'b0;
				end else begin
					res.pixel_write = 1'b1;
					res.pixel_index = (st.mode == dswl_pkg::MODE_ASC) ? st.position
						: desc_idx[dswl_pkg::PIX_W-1:0];
					res.pixel_red   = cfg.red;
					res.pixel_green = cfg.green;
					res.pixel_blue  = cfg.blue;
					if (pos_inc == cfg.length) begin
						nxt.mode     = dswl_pkg::MODE_HOLD;
						nxt.position = '0;
						nxt.started  = 1'b0;
					end else begin
						nxt.position = pos_inc[dswl_pkg::PIX_W-1:0];
					end
				end
			end
			default: begin
				if (!cl && !cr) begin
					res.clear_strip = 1'b1;
					nxt.mode        = dswl_pkg::MODE_IDLE;
				end
			end
		endcase
		if (!keep_hist) begin
			nxt.prev_left  = cl;
			nxt.prev_right = cr;
		end
		res.mode           = nxt.mode;
		res.left_triggers  = nxt.left_count;
		res.right_triggers = nxt.right_count;
		res.conflicts      = nxt.conflict_count;
	end

endmodule

[hdl/dual_sensor_wipe_light_fsm.sv]
// Dual-sensor wipe light controller, top level.
// Depends on dswl_pkg, dswl_in_if, dswl_out_if, dswl_cfg_regs, dswl_step.
//
//   channel   dir   handshake        payload
//   sensor    in    valid/ready      sensor_left, sensor_right
//   light     out   valid/ready      mode, pixel cmd, clear_strip, counters
//   cfg_*     in    cfg_we           cfg_index, cfg_data
//
// The input register feeds step logic into the result register, which also
// updates the controller state. One tick per clock while the result register is not stalled.
// Reset clears state and loads register defaults; no clearing pass.
// A stalled result register holds the input stage; ready drops only then.
module dual_sensor_wipe_light_fsm #(
	parameter int MAX_PIXELS = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	dswl_in_if.sink                     sensor,
	dswl_out_if.source                  light,
	input  logic                        cfg_we,
	input  logic [dswl_pkg::IDX_W-1:0]  cfg_index,
	input  logic [dswl_pkg::LEN_W-1:0]  cfg_data
);

	dswl_pkg::cfg_t    cfg;
	dswl_pkg::state_t  state_q;
	dswl_pkg::state_t  state_nxt;
	dswl_pkg::result_t res;
	dswl_pkg::result_t res_q;
	logic              valid_s1;
	logic              left_s1;
	logic              right_s1;
	logic              out_valid_q;
	logic              advance;

	dswl_cfg_regs #(.MAX_PIXELS(MAX_PIXELS)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dswl_step u_step (
		.st  (state_q),
		.cfg (cfg),
		.cl  (left_s1),
		.cr  (right_s1),
		.nxt (state_nxt),
		.res (res)
	);

	assign advance      = !out_valid_q || light.ready;
	assign sensor.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= '0;
		end else begin
			if (sensor.ready)
				valid_s1 <= sensor.valid;
			if (advance) begin
				out_valid_q <= valid_s1;
				if (valid_s1)
					state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sensor.ready) begin
			left_s1  <= sensor.sensor_left;
			right_s1 <= sensor.sensor_right;
		end
		if (advance && valid_s1)
			res_q <= res;
	end

	assign light.valid          = out_valid_q;
	assign light.mode           = res_q.mode;
	assign light.pixel_write    = res_q.pixel_write;
	assign light.pixel_index    = res_q.pixel_index;
	assign light.pixel_red      = res_q.pixel_red;
	assign light.pixel_green    = res_q.pixel_green;
	assign light.pixel_blue     = res_q.pixel_blue;
	assign light.clear_strip    = res_q.clear_strip;
	assign light.left_triggers  = res_q.left_triggers;
	assign light.right_triggers = res_q.right_triggers;
	assign light.conflicts      = res_q.conflicts;

endmodule

[tb/dual_sensor_wipe_light_fsm_test.sv]
// Testbench for dual_sensor_wipe_light_fsm: directed table, then random sensor ticks.
// Every tick result is checked against its directed-table value or else a local wipe/hold predictor.
// Depends on dswl_pkg, dswl_in_if, dswl_out_if and the block itself.
`timescale 1ns / 100ps

module dual_sensor_wipe_light_fsm_test;

	localparam int PIXELS_MAX = 256;
	localparam int unsigned PHASE_LEN [9] = '{3, 1, 0, 7, 2, 256, 511, 5, 300};

	typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t                          kind;
		logic                               left;
		logic                               right;
		logic [dswl_pkg::IDX_W-1:0]         idx;
		logic [dswl_pkg::LEN_W-1:0]         data;
		bit                                 typed;
		dswl_pkg::result_t                  want;
	} row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [dswl_pkg::IDX_W-1:0] cfg_index;
	logic [dswl_pkg::LEN_W-1:0] cfg_data;

	dswl_in_if  sensor_ch ();
	dswl_out_if light_ch ();

	dual_sensor_wipe_light_fsm #(
		.MAX_PIXELS(PIXELS_MAX)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sensor    (sensor_ch),
		.light     (light_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	dswl_pkg::state_t  wipe_st;
	dswl_pkg::cfg_t    wipe_cfg;
	dswl_pkg::result_t light_expect_q [$];
	row_t              dir_rows [$];
	int unsigned       mismatch_cnt;
	int unsigned       idle_pct;
	int unsigned       stall_pct;
	bit                hold_req;

	always #5 clk = ~clk;

	function automatic dswl_pkg::result_t wipe_step(logic l, logic r);
		dswl_pkg::result_t res;
		logic              edge_l;
		logic              edge_r;
		logic              keep;
		int unsigned       len;
		int unsigned       pos;
		int unsigned       pix;
		res = '0;
		keep = 1'b0;
		edge_l = l && !wipe_st.prev_left;
		edge_r = r && !wipe_st.prev_right;
		case (wipe_st.mode)
			dswl_pkg::MODE_IDLE: begin
				if (edge_l) begin
					wipe_st.mode = dswl_pkg::MODE_ASC;
					wipe_st.left_count = wipe_st.left_count + 1;
					if (edge_r)
						wipe_st.conflict_count = wipe_st.conflict_count + 1;
					wipe_st.position = '0;
					wipe_st.started = 1'b0;
				end else if (edge_r) begin
					wipe_st.mode = dswl_pkg::MODE_DESC;
					wipe_st.right_count = wipe_st.right_count + 1;
					wipe_st.position = '0;
					wipe_st.started = 1'b0;
				end
			end
			dswl_pkg::MODE_ASC, dswl_pkg::MODE_DESC: begin
				len = wipe_cfg.length;
				if (len < 1)
					len = 1;
				if (len > PIXELS_MAX)
					len = PIXELS_MAX;
				pos = wipe_st.position;
				keep = wipe_st.started;
				wipe_st.started = 1'b1;
				if (pos >= len) begin
					wipe_st.mode = dswl_pkg::MODE_HOLD;
					wipe_st.position = '0;
					wipe_st.started = 1'b0;
				end else begin
					pix = (wipe_st.mode == dswl_pkg::MODE_ASC) ? pos : len - 1 - pos;
					res.pixel_write = 1'b1;
					res.pixel_index = pix[dswl_pkg::PIX_W-1:0];
					res.pixel_red = wipe_cfg.red;
					res.pixel_green = wipe_cfg.green;
					res.pixel_blue = wipe_cfg.blue;
					if (pos == len - 1) begin
						wipe_st.mode = dswl_pkg::MODE_HOLD;
						wipe_st.position = '0;
						wipe_st.started = 1'b0;
					end else begin
						wipe_st.position = dswl_pkg::PIX_W'(pos + 1);
					end
				end
			end
			default: begin
				if (!l && !r) begin
					res.clear_strip = 1'b1;
					wipe_st.mode = dswl_pkg::MODE_IDLE;
				end
			end
		endcase
		if (!keep) begin
			wipe_st.prev_left = l;
			wipe_st.prev_right = r;
		end
		res.mode = wipe_st.mode;
		res.left_triggers = wipe_st.left_count;
		res.right_triggers = wipe_st.right_count;
		res.conflicts = wipe_st.conflict_count;
		return res;
	endfunction

	function automatic dswl_pkg::result_t light_res(logic [1:0] mode, int unsigned wr,
		int unsigned index, int unsigned red, int unsigned green, int unsigned blue,
		int unsigned clr, int unsigned lt, int unsigned rt, int unsigned cf);
		dswl_pkg::result_t res;
		res.mode = mode;
		res.pixel_write = 1'(wr);
		res.pixel_index = index[dswl_pkg::PIX_W-1:0];
		res.pixel_red = red[dswl_pkg::COLOR_W-1:0];
		res.pixel_green = green[dswl_pkg::COLOR_W-1:0];
		res.pixel_blue = blue[dswl_pkg::COLOR_W-1:0];
		res.clear_strip = 1'(clr);
		res.left_triggers = lt;
		res.right_triggers = rt;
		res.conflicts = cf;
		return res;
	endfunction

	function automatic void tick_row(int unsigned l, int unsigned r);
		dir_rows.push_back('{ROW_TICK, 1'(l), 1'(r), '0, '0, 1'b0, '0});
	endfunction

	function automatic void tick_row_exp(int unsigned l, int unsigned r,
		dswl_pkg::result_t want);
		dir_rows.push_back('{ROW_TICK, 1'(l), 1'(r), '0, '0, 1'b1, want});
	endfunction

	function automatic void reg_row(logic [dswl_pkg::IDX_W-1:0] idx,
		logic [dswl_pkg::LEN_W-1:0] data);
		dir_rows.push_back('{ROW_CFG, 1'b0, 1'b0, idx, data, 1'b0, '0});
	endfunction

	// Drops valid and waits until every result in flight has come back.
	task automatic drain();
		sensor_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (light_expect_q.size() != 0);
	endtask

	// Leaves cfg_we high; the next tick lowers it.
	task automatic write_reg(logic [dswl_pkg::IDX_W-1:0] idx,
		logic [dswl_pkg::LEN_W-1:0] data);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			dswl_pkg::REG_STRIP_LENGTH: wipe_cfg.length = data;
			dswl_pkg::REG_WIPE_RED:     wipe_cfg.red = data[dswl_pkg::COLOR_W-1:0];
			dswl_pkg::REG_WIPE_GREEN:   wipe_cfg.green = data[dswl_pkg::COLOR_W-1:0];
			default:                    wipe_cfg.blue = data[dswl_pkg::COLOR_W-1:0];
		endcase
	endtask

	task automatic send(logic l, logic r, bit typed, dswl_pkg::result_t want);
		int unsigned       gap;
		dswl_pkg::result_t pred;
		gap = 0;
		while (gap < 20 && $urandom_range(99) < idle_pct)
			gap++;
		cfg_we <= 1'b0;
		if (gap != 0) begin
			sensor_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sensor_ch.valid <= 1'b1;
		sensor_ch.sensor_left <= l;
		sensor_ch.sensor_right <= r;
		do
			@(posedge clk);
		while (!sensor_ch.ready);
		pred = wipe_step(l, r);
		light_expect_q.push_back(typed ? want : pred);
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			mismatch_cnt++;
			if (mismatch_cnt <= 40)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : light_mon
		dswl_pkg::result_t want;
		if (arst_n && light_ch.valid && light_ch.ready) begin
			if (light_expect_q.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 40)
					$display("%0t: unexpected transfer, expected none, actual mode %0d index %0d",
						$time, light_ch.mode, light_ch.pixel_index);
			end else begin
				want = light_expect_q.pop_front();
				check_field("mode", want.mode, light_ch.mode);
				check_field("pixel_write", want.pixel_write, light_ch.pixel_write);
				check_field("pixel_index", want.pixel_index, light_ch.pixel_index);
				check_field("pixel_red", want.pixel_red, light_ch.pixel_red);
				check_field("pixel_green", want.pixel_green, light_ch.pixel_green);
				check_field("pixel_blue", want.pixel_blue, light_ch.pixel_blue);
				check_field("clear_strip", want.clear_strip, light_ch.clear_strip);
				check_field("left_triggers", want.left_triggers, light_ch.left_triggers);
				check_field("right_triggers", want.right_triggers, light_ch.right_triggers);
				check_field("conflicts", want.conflicts, light_ch.conflicts);
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin : light_sink
		int unsigned hold_left;
		bit          hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		light_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = 400;
			end
			if (hold_left != 0) begin
				hold_left--;
				light_ch.ready <= 1'b0;
			end else begin
				light_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin : stim
		int unsigned roll;
		logic        l;
		logic        r;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sensor_ch.valid = 1'b0;
		sensor_ch.sensor_left = 1'b0;
		sensor_ch.sensor_right = 1'b0;
		mismatch_cnt = 0;
		idle_pct = 0;
		stall_pct = 0;
		hold_req = 1'b0;
		wipe_st = '0;
		wipe_cfg = '{dswl_pkg::RST_STRIP_LENGTH, dswl_pkg::RST_WIPE_RED,
			dswl_pkg::RST_WIPE_GREEN, dswl_pkg::RST_WIPE_BLUE};

		// reset colors, then shrink mid-wipe
		tick_row_exp(0, 0, light_res(dswl_pkg::MODE_IDLE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		tick_row_exp(1, 0, light_res(dswl_pkg::MODE_ASC, 0, 0, 0, 0, 0, 0, 1, 0, 0));
		tick_row_exp(1, 0, light_res(dswl_pkg::MODE_ASC, 1, 0, 50, 40, 0, 0, 1, 0, 0));
		reg_row(dswl_pkg::REG_STRIP_LENGTH, 9'd1);
		tick_row_exp(0, 1, light_res(dswl_pkg::MODE_HOLD, 0, 0, 0, 0, 0, 0, 1, 0, 0));
		tick_row_exp(0, 1, light_res(dswl_pkg::MODE_HOLD, 0, 0, 0, 0, 0, 0, 1, 0, 0));
		tick_row_exp(0, 0, light_res(dswl_pkg::MODE_IDLE, 0, 0, 0, 0, 0, 1, 1, 0, 0));
		// both edges together, zero length acts as one
		reg_row(dswl_pkg::REG_WIPE_RED, 9'd255);
		reg_row(dswl_pkg::REG_WIPE_GREEN, 9'd255);
		reg_row(dswl_pkg::REG_WIPE_BLUE, 9'd255);
		reg_row(dswl_pkg::REG_STRIP_LENGTH, 9'd0);
		tick_row_exp(1, 1, light_res(dswl_pkg::MODE_ASC, 0, 0, 0, 0, 0, 0, 2, 0, 1));
		tick_row_exp(1, 1, light_res(dswl_pkg::MODE_HOLD, 1, 0, 255, 255, 255, 0, 2, 0, 1));
		tick_row(1, 1);
		tick_row_exp(0, 0, light_res(dswl_pkg::MODE_IDLE, 0, 0, 0, 0, 0, 1, 2, 0, 1));
		// oversized length clamps, descending from the top pixel
		reg_row(dswl_pkg::REG_STRIP_LENGTH, 9'd511);
		reg_row(dswl_pkg::REG_WIPE_RED, 9'd0);
		reg_row(dswl_pkg::REG_WIPE_GREEN, 9'd0);
		reg_row(dswl_pkg::REG_WIPE_BLUE, 9'd0);
		tick_row_exp(0, 1, light_res(dswl_pkg::MODE_DESC, 0, 0, 0, 0, 0, 0, 2, 1, 1));
		tick_row_exp(0, 0, light_res(dswl_pkg::MODE_DESC, 1, 255, 0, 0, 0, 0, 2, 1, 1));
		tick_row_exp(1, 1, light_res(dswl_pkg::MODE_DESC, 1, 254, 0, 0, 0, 0, 2, 1, 1));
		reg_row(dswl_pkg::REG_STRIP_LENGTH, 9'd2);
		tick_row(1, 0);
		tick_row(1, 1);
		tick_row(0, 0);
		reg_row(dswl_pkg::REG_WIPE_RED, 9'h0A5);
		reg_row(dswl_pkg::REG_WIPE_GREEN, 9'h05A);
		reg_row(dswl_pkg::REG_WIPE_BLUE, 9'h0C3);
		tick_row(0, 1);
		tick_row(0, 1);
		tick_row(1, 0);
		tick_row(1, 1);
		tick_row(0, 0);
		tick_row(1, 0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG)
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			else
				send(dir_rows[i].left, dir_rows[i].right, dir_rows[i].typed, dir_rows[i].want);
		end

		for (int p = 0; p < 9; p++) begin
			write_reg(dswl_pkg::REG_STRIP_LENGTH, dswl_pkg::LEN_W'(PHASE_LEN[p]));
			write_reg(dswl_pkg::REG_WIPE_RED, dswl_pkg::LEN_W'($urandom_range(255)));
			write_reg(dswl_pkg::REG_WIPE_GREEN, dswl_pkg::LEN_W'($urandom_range(255)));
			write_reg(dswl_pkg::REG_WIPE_BLUE, dswl_pkg::LEN_W'($urandom_range(255)));
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 71; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 71; end
				default: begin idle_pct = 16; stall_pct = 16; end
			endcase
			for (int k = 0; k < 105; k++) begin
				if (p == 4 && k == 10)
					hold_req = 1'b1;
				if (p == 6 && k == 50)
					drain();
				roll = $urandom_range(99);
				l = 1'($urandom_range(1));
				r = 1'($urandom_range(1));
				// steer toward full wipe / hold / release cycles, with some noise
				if (roll >= 10) begin
					if (wipe_st.mode == dswl_pkg::MODE_IDLE && roll < 40) begin
						l = 1'b0;
						r = 1'b0;
					end else if (wipe_st.mode == dswl_pkg::MODE_HOLD && roll < 55) begin
						l = 1'b0;
						r = 1'b0;
					end
				end
				send(l, r, 1'b0, '0);
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
